/* rtl/core/sibm_pkg.sv */
`default_nettype none
package sibm_pkg;

  // Remainder lanes: pairs 0..3, singles 4..7 use the CHR count; lanes 8, 9 use the PRG count
  localparam int unsigned NumLanes  = 10;
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned NumSteps  = 8 / BitsPerStep;
  localparam logic [1:0]  StepLast  = 2'(NumSteps - 1);

  localparam int unsigned LaneB6 = 8;
  localparam int unsigned LaneB7 = 9;

  // Configuration register indexes
  localparam logic [1:0] CfgPrgCount  = 2'd0;
  localparam logic [1:0] CfgChrCount  = 2'd1;
  localparam logic [1:0] CfgFourScreen = 2'd2;

  // Register select formed from {address[14:13], address[6]} when address[15] is set
  typedef enum logic [2:0] {
    REG_BANK_SELECT = 3'b000,
    REG_BANK_DATA   = 3'b001,
    REG_MIRROR      = 3'b010,
    REG_UNUSED      = 3'b011,
    REG_IRQ_LATCH   = 3'b100,
    REG_IRQ_RELOAD  = 3'b101,
    REG_IRQ_DISABLE = 3'b110,
    REG_IRQ_ENABLE  = 3'b111
  } reg_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic apply;     // take the input word into the mapper state
    logic step;      // advance the remainder lanes
    logic load_out;  // capture the finished map into the output register
  } sibm_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/sibm_ctrl.sv */
`default_nettype none
module sibm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sibm_pkg::sibm_cmd_t    cmd_o
);
  import sibm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          step_d      = '0;
          state_d     = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 2'd1;
        if (step_q == StepLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/core/sibm_dp.sv */
`default_nettype none
module sibm_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sibm_pkg::sibm_cmd_t cmd_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i,
  input  wire logic              operation_i,
  input  wire logic [15:0]       address_i,
  input  wire logic [7:0]        data_i,
  input  wire logic              rendering_enabled_i,
  output logic [31:0]            prg_map_o,
  output logic [63:0]            chr_map_o,
  output logic                   mirror_update_o,
  output logic                   mirror_horizontal_o,
  output logic                   irq_raise_o,
  output logic                   irq_clear_o
);
  import sibm_pkg::*;

  // Two restoring remainder steps; for a nonzero n the remainder stays below n
  function automatic logic [7:0] rem_step2(input logic [7:0] rem, input logic [1:0] bits,
                                           input logic [7:0] n);
    logic [8:0] r;
    logic [7:0] cur;
    cur = rem;
    for (int k = 1; k >= 0; k--) begin
      r = {cur, bits[k]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
      cur = r[7:0];
    end
    return cur;
  endfunction

  // configuration
  logic [7:0] prg_cnt_q, chr_cnt_q;
  logic       four_q;

  // mapper state
  logic [7:0] select_q, select_d;
  logic [7:0] bank_q [8];
  logic [7:0] bank_d [8];
  logic       mirror_q, mirror_d;
  logic [7:0] latch_q, latch_d;
  logic [7:0] count_q, count_d;
  logic       reload_q, reload_d;
  logic       irq_en_q, irq_en_d;

  // per-item flags
  logic       m_upd_q, m_upd_d;
  logic       raise_q, raise_d;
  logic       clr_q, clr_d;

  // remainder lanes
  logic [7:0] lane_val_q [NumLanes];
  logic [7:0] lane_rem_q [NumLanes];
  logic [7:0] lane_init  [NumLanes];

  reg_sel_e   sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= 8'd16;
      chr_cnt_q <= 8'd8;
      four_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPrgCount:   prg_cnt_q <= cfg_data_i;
        CfgChrCount:   chr_cnt_q <= cfg_data_i;
        CfgFourScreen: four_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign sel = reg_sel_e'({address_i[14:13], address_i[6]});

  always_comb begin
    select_d = select_q;
    bank_d   = bank_q;
    mirror_d = mirror_q;
    latch_d  = latch_q;
    count_d  = count_q;
    reload_d = reload_q;
    irq_en_d = irq_en_q;
    m_upd_d  = 1'b0;
    raise_d  = 1'b0;
    clr_d    = 1'b0;
    if (!operation_i) begin
      if (address_i[15]) begin
        case (sel)
          REG_BANK_SELECT: select_d = data_i;
          REG_BANK_DATA:   bank_d[select_q[2:0]] = data_i;
          REG_MIRROR: begin
            mirror_d = data_i[0];
            m_upd_d  = !four_q;
          end
          REG_IRQ_LATCH:   latch_d = data_i;
          REG_IRQ_RELOAD:  reload_d = 1'b1;
          REG_IRQ_DISABLE: begin
            irq_en_d = 1'b0;
            clr_d    = 1'b1;
          end
          REG_IRQ_ENABLE:  irq_en_d = 1'b1;
          default: ;
        endcase
      end
    end else if (rendering_enabled_i) begin
      if (count_q == 8'd0 || reload_q) begin
        count_d = latch_q;
      end else begin
        count_d = count_q - 8'd1;
      end
      raise_d  = (count_d == 8'd0) && irq_en_q;
      reload_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q <= '0;
      for (int i = 0; i < 7; i++) begin
        bank_q[i] <= '0;
      end
      bank_q[7] <= 8'd1;
      mirror_q  <= 1'b0;
      latch_q   <= '0;
      count_q   <= '0;
      reload_q  <= 1'b0;
      irq_en_q  <= 1'b0;
    end else if (cmd_i.apply) begin
      select_q <= select_d;
      bank_q   <= bank_d;
      mirror_q <= mirror_d;
      latch_q  <= latch_d;
      count_q  <= count_d;
      reload_q <= reload_d;
      irq_en_q <= irq_en_d;
    end
  end

  always_comb begin
    lane_init[0] = {bank_d[0][7:1], 1'b0};
    lane_init[1] = {bank_d[0][7:1], 1'b1};
    lane_init[2] = {bank_d[1][7:1], 1'b0};
    lane_init[3] = {bank_d[1][7:1], 1'b1};
    for (int i = 0; i < 4; i++) begin
      lane_init[4 + i] = bank_d[2 + i];
    end
    lane_init[LaneB6] = bank_d[6];
    lane_init[LaneB7] = bank_d[7];
  end

  // Lanes run MSB first, two dividend bits per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      m_upd_q <= m_upd_d;
      raise_q <= raise_d;
      clr_q   <= clr_d;
      for (int i = 0; i < NumLanes; i++) begin
        lane_val_q[i] <= lane_init[i];
        lane_rem_q[i] <= '0;
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < NumLanes; i++) begin
        lane_val_q[i] <= {lane_val_q[i][5:0], 2'b00};
        lane_rem_q[i] <= rem_step2(lane_rem_q[i], lane_val_q[i][7:6],
                                   (i < 8) ? chr_cnt_q : prg_cnt_q);
      end
    end
  end

  logic [7:0]  b6, b7, last, slast;
  logic [31:0] prg_d;
  logic [63:0] chr_d;

  always_comb begin
    b6    = (prg_cnt_q == 8'd0) ? 8'd0 : lane_rem_q[LaneB6];
    b7    = (prg_cnt_q == 8'd0) ? 8'd0 : lane_rem_q[LaneB7];
    last  = prg_cnt_q - 8'd1;
    slast = prg_cnt_q - 8'd2;
    if (!select_q[6]) begin
      prg_d = {last, slast, b7, b6};
    end else begin
      prg_d = {last, b6, b7, slast};
    end
    chr_d = '0;
    if (chr_cnt_q == 8'd0) begin
      // character RAM: identity map
      for (int i = 0; i < 8; i++) begin
        chr_d[8*i +: 8] = 8'(i);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (!select_q[7]) begin
          chr_d[8*i +: 8]       = lane_rem_q[i];
          chr_d[8*(i + 4) +: 8] = lane_rem_q[4 + i];
        end else begin
          chr_d[8*(i + 4) +: 8] = lane_rem_q[i];
          chr_d[8*i +: 8]       = lane_rem_q[4 + i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      prg_map_o           <= prg_d;
      chr_map_o           <= chr_d;
      mirror_update_o     <= m_upd_q;
      mirror_horizontal_o <= mirror_q;
      irq_raise_o         <= raise_q;
      irq_clear_o         <= clr_q;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/scanline_irq_bank_mapper.sv */
// An accepted word is registered into the mapper state; the bank reduction then runs four
// remainder steps of two bits each, and the result is then loaded into the output register.
// Input is stalled until the word in progress has been loaded into the output register.
// A new word is taken while the previous result still waits on a stalled output.
// Reset (rst_ni low, asynchronous) restores default bank counts and resets mapper state (bank 7 to 1, the rest to 0).
`default_nettype none
module scanline_irq_bank_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        rendering_enabled_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      prg_map_o,
  output logic [63:0]      chr_map_o,
  output logic             mirror_update_o,
  output logic             mirror_horizontal_o,
  output logic             irq_raise_o,
  output logic             irq_clear_o
);
  import sibm_pkg::*;

  sibm_cmd_t cmd;

  sibm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sibm_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .operation_i         (operation_i),
    .address_i           (address_i),
    .data_i              (data_i),
    .rendering_enabled_i (rendering_enabled_i),
    .prg_map_o           (prg_map_o),
    .chr_map_o           (chr_map_o),
    .mirror_update_o     (mirror_update_o),
    .mirror_horizontal_o (mirror_horizontal_o),
    .irq_raise_o         (irq_raise_o),
    .irq_clear_o         (irq_clear_o)
  );

endmodule
`default_nettype wire
